[src/opb_pkg.sv]
// shared types, constants and coefficient tables for the polynomial basis evaluator
package opb_pkg;

  // largest number of basis polynomials per sample
  localparam int MAX_BASIS = 16;
  localparam int IDX_W     = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int CNT_W     = $clog2(MAX_BASIS + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_SIZE = 2'd1;
  localparam logic [CFG_DATA_W-1:0] BASIS_SIZE_RESET = 5'd8;

  // basis kinds
  localparam logic KIND_HERMITE  = 1'b0;
  localparam logic KIND_LEGENDRE = 1'b1;

  // fixed point constants
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] POS_LIM  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TWO_P62  = 64'h4000_0000_0000_0000;
  localparam int          LO_W     = 36;

  // scale of a coefficient product
  typedef enum logic [1:0] {
    SH_28,
    SH_30,
    SH_31
  } sh_sel_t;

  // which product of a recurrence step is formed
  typedef enum logic [1:0] {
    OP_T,
    OP_P,
    OP_Q
  } op_t;

  // multiply unit phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_SUM,
    PH_NEG
  } mrs_phase_t;

  // sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EMIT,
    SQ_MGO,
    SQ_MWAIT,
    SQ_SUB
  } seq_state_t;

  // request to the multiply unit
  typedef struct packed {
    logic        start;
    logic [63:0] v;
    logic [31:0] c;
    logic        cneg;
    sh_sel_t     sh;
  } mrs_req_t;

  // result handed to the output register
  typedef struct packed {
    logic        load;
    logic [3:0]  poly_index;
    logic [63:0] poly_value;
    logic        last;
  } emit_t;

  // coefficient table selection
  typedef enum logic [1:0] {
    COEF_R,
    COEF_S,
    COEF_A,
    COEF_B
  } coef_sel_t;

  typedef logic [31:0] coef_arr_t [MAX_BASIS];

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor square root, elaboration only
  function automatic logic [31:0] isqrt64(input logic [63:0] t);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (({32'b0, c} * {32'b0, c}) <= t) begin
        r = c;
      end
    end
    return r;
  endfunction

  // recurrence coefficients for degree i
  function automatic coef_arr_t build_coef(input coef_sel_t sel);
    coef_arr_t   tab;
    logic [63:0] k;
    logic [63:0] iv;
    for (int i = 0; i < MAX_BASIS; i++) begin
      iv = 64'(i);
      k  = iv + 64'd1;
      case (sel)
        COEF_R:  tab[i] = isqrt64(udiv64(TWO_P62, k));
        COEF_S:  tab[i] = isqrt64(TWO_P62 - udiv64(TWO_P62 + iv, k));
        COEF_A:  tab[i] = 32'(udiv64((((iv << 1) + 64'd1) << 30) + (k >> 1), k));
        COEF_B:  tab[i] = 32'(udiv64((iv << 31) + (k >> 1), k));
        default: tab[i] = '0;
      endcase
    end
    return tab;
  endfunction

  localparam coef_arr_t HERM_R_TAB = build_coef(COEF_R);
  localparam coef_arr_t HERM_S_TAB = build_coef(COEF_S);
  localparam coef_arr_t LEG_A_TAB  = build_coef(COEF_A);
  localparam coef_arr_t LEG_B_TAB  = build_coef(COEF_B);

endpackage

[src/opb_mrs_unit.sv]
// shared multi-cycle multiply, round half away from zero and saturate unit
module opb_mrs_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  opb_pkg::mrs_req_t req,
  output logic              done,
  output logic [63:0]       res
);
  import opb_pkg::*;

  mrs_phase_t        phase_r, phase_nxt;
  logic              neg_r;
  logic [63:0]       mag_r;
  logic [31:0]       c_r;
  sh_sel_t           sh_r;
  logic [LO_W-1:0]   lo_r;
  logic [63:0]       hi_r;
  logic              ovf_r;
  logic [63:0]       m_r;

  logic [31:0]       mul_a;
  logic [63:0]       prod;
  logic [4:0]        sh_amt;
  logic [2:0]        k_amt;
  logic [63:0]       rnd;
  logic [63:0]       thr;
  logic [63:0]       lim;
  logic [63:0]       lo_full;
  logic [63:0]       sum;

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (req.start) phase_nxt = PH_LO;
      PH_LO:   phase_nxt = PH_HI;
      PH_HI:   phase_nxt = PH_SUM;
      PH_SUM:  phase_nxt = PH_NEG;
      PH_NEG:  phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // outputs: result shown during the last phase
  always_comb begin
    done = (phase_r == PH_NEG);
    res  = neg_r ? (~m_r + 64'd1) : m_r;
  end

  // scale selection
  always_comb begin
    case (sh_r)
      SH_28: begin
        sh_amt = 5'd28;
        k_amt  = 3'd4;
      end
      SH_30: begin
        sh_amt = 5'd30;
        k_amt  = 3'd2;
      end
      SH_31: begin
        sh_amt = 5'd31;
        k_amt  = 3'd1;
      end
      default: begin
        sh_amt = 5'd31;
        k_amt  = 3'd1;
      end
    endcase
  end

  // the one 32x32 multiplier, low half first then high half
  always_comb begin
    mul_a   = (phase_r == PH_HI) ? mag_r[63:32] : mag_r[31:0];
    prod    = 64'(mul_a) * 64'(c_r);
    rnd     = 64'd1 << (sh_amt - 5'd1);
    lo_full = (prod + rnd) >> sh_amt;
    thr     = 64'd1 << (6'd63 - 6'(k_amt));
    lim     = neg_r ? NEG_LIM : POS_LIM;
    sum     = (hi_r << k_amt) + 64'(lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          neg_r <= req.v[63] ^ req.cneg;
          mag_r <= req.v[63] ? (~req.v + 64'd1) : req.v;
          c_r   <= req.c;
          sh_r  <= req.sh;
        end
      end
      PH_LO: begin
        lo_r <= lo_full[LO_W-1:0];
      end
      PH_HI: begin
        hi_r  <= prod;
        ovf_r <= neg_r ? (prod > thr) : (prod >= thr);
      end
      PH_SUM: begin
        m_r <= (ovf_r || (sum > lim)) ? lim : sum;
      end
      default: begin
      end
    endcase
  end

endmodule

[src/opb_seq.sv]
// recurrence sequencer: holds the running terms and drives the multiply unit
module opb_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [31:0]              in_value,
  output logic                            in_ready,
  input  logic                            basis_kind,
  input  logic [opb_pkg::CFG_DATA_W-1:0]  basis_size,
  input  logic                            slot_free,
  output opb_pkg::emit_t                  emit,
  output opb_pkg::mrs_req_t               req,
  input  logic                            mrs_done,
  input  logic [63:0]                     mrs_res
);
  import opb_pkg::*;

  seq_state_t        state_r, state_nxt;
  op_t               op_r;
  logic [IDX_W-1:0]  i_r;
  logic [CNT_W-1:0]  n_r;
  logic              xneg_r;
  logic [31:0]       xmag_r;
  logic [63:0]       cur_r;
  logic [63:0]       prev_r;
  logic [63:0]       t_r;
  logic [63:0]       p_r;

  logic [31:0]       vin_u;
  logic [CNT_W-1:0]  n_eff;
  logic              is_last;
  logic              accept;
  logic [64:0]       diff;
  logic [63:0]       diff_sat;

  // effective run length, clamped to 1..MAX_BASIS
  always_comb begin
    if (basis_size == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(basis_size) > MAX_BASIS) begin
      n_eff = CNT_W'(MAX_BASIS);
    end else begin
      n_eff = CNT_W'(basis_size);
    end
  end

  assign vin_u   = in_value;
  assign is_last = (CNT_W'(i_r) == (n_r - CNT_W'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE:  if (in_valid) state_nxt = SQ_EMIT;
      SQ_EMIT:  if (slot_free) state_nxt = is_last ? SQ_IDLE : SQ_MGO;
      SQ_MGO:   state_nxt = SQ_MWAIT;
      SQ_MWAIT: if (mrs_done) state_nxt = (op_r == OP_Q) ? SQ_SUB : SQ_MGO;
      SQ_SUB:   state_nxt = SQ_EMIT;
      default:  state_nxt = SQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state_r == SQ_IDLE);
    emit.load       = (state_r == SQ_EMIT) && slot_free;
    emit.poly_index = 4'(i_r);
    emit.poly_value = cur_r;
    emit.last       = is_last;
    req.start       = (state_r == SQ_MGO);
    case (op_r)
      OP_T: begin
        req.v    = cur_r;
        req.c    = xmag_r;
        req.cneg = xneg_r;
        req.sh   = SH_28;
      end
      OP_P: begin
        req.v    = t_r;
        req.c    = (basis_kind == KIND_LEGENDRE) ? LEG_A_TAB[i_r] : HERM_R_TAB[i_r];
        req.cneg = 1'b0;
        req.sh   = (basis_kind == KIND_LEGENDRE) ? SH_30 : SH_31;
      end
      OP_Q: begin
        req.v    = prev_r;
        req.c    = (basis_kind == KIND_LEGENDRE) ? LEG_B_TAB[i_r] : HERM_S_TAB[i_r];
        req.cneg = 1'b0;
        req.sh   = SH_31;
      end
      default: begin
        req.v    = cur_r;
        req.c    = xmag_r;
        req.cneg = xneg_r;
        req.sh   = SH_28;
      end
    endcase
  end

  // saturating difference of the two products
  always_comb begin
    diff = {p_r[63], p_r} - {mrs_res[63], mrs_res};
    if (diff[64] != diff[63]) begin
      diff_sat = diff[64] ? NEG_LIM : POS_LIM;
    end else begin
      diff_sat = diff[63:0];
    end
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      op_r    <= OP_T;
    end else begin
      state_r <= state_nxt;
      if (state_r == SQ_EMIT) begin
        op_r <= OP_T;
      end else if ((state_r == SQ_MWAIT) && mrs_done) begin
        case (op_r)
          OP_T:    op_r <= OP_P;
          OP_P:    op_r <= OP_Q;
          default: op_r <= OP_T;
        endcase
      end
    end
  end

  // running terms and sample
  always_ff @(posedge clk) begin
    if (accept) begin
      xneg_r <= vin_u[31];
      xmag_r <= vin_u[31] ? (~vin_u + 32'd1) : vin_u;
      n_r    <= n_eff;
      i_r    <= '0;
      cur_r  <= ONE_Q32;
      prev_r <= '0;
    end
    if ((state_r == SQ_MWAIT) && mrs_done) begin
      case (op_r)
        OP_T: t_r <= mrs_res;
        OP_P: p_r <= mrs_res;
        default: begin
        end
      endcase
    end
    // q arrives in the wait state; subtraction registered here too
    if ((state_r == SQ_MWAIT) && mrs_done && (op_r == OP_Q)) begin
      prev_r <= cur_r;
      cur_r  <= diff_sat;
    end
    if (state_r == SQ_SUB) begin
      i_r <= i_r + IDX_W'(1);
    end
  end

endmodule

[src/orthonormal_polynomial_basis_eval.sv]
// top level of the orthonormal polynomial basis evaluator
//
// One sample (in_value, signed Q4.28) is taken per request on the in_ channel.
// For it the block returns basis_size results on the out_ channel, degree 0
// first: out_poly_index, out_poly_value (signed Q32.32, saturated) and out_last
// on the final degree. Register basis_kind selects normalized Hermite (0) or
// Legendre (1); both registers are written through cfg_we/cfg_index/cfg_data.
// The user must write them only while the block is idle; it is not enforced.
// The degree 0 result is loaded into the output register from the emit state.
// For each further degree a single 32x32 multiplier in the shared multiply
// unit forms six partial products per recurrence step (low and high half of
// each of the three scaled products), followed by an update and an emit state.
// in_ready stays low until the last result of a sample is loaded for output.
// The output register decouples the sides: a stalled out_ready holds the
// current result and the sequencer waits at its next emit; the last result
// may still wait while a new sample is taken.
// Reset (rst_n low, synchronous) returns to idle, drops out_valid and sets
// basis_kind to Hermite and basis_size to 8.
module orthonormal_polynomial_basis_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [31:0]              in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      out_poly_index,
  output logic signed [63:0]              out_poly_value,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [opb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [opb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import opb_pkg::*;

  logic                  kind_r;
  logic [CFG_DATA_W-1:0] size_r;
  logic                  out_valid_r;
  logic [3:0]            out_index_r;
  logic [63:0]           out_value_r;
  logic                  out_last_r;
  logic                  slot_free;
  emit_t                 emit;
  mrs_req_t              req;
  logic                  mrs_done;
  logic [63:0]           mrs_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_HERMITE;
      size_r <= BASIS_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASIS_KIND: kind_r <= cfg_data[0];
        REG_BASIS_SIZE: size_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // output register
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_index_r <= emit.poly_index;
      out_value_r <= emit.poly_value;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_poly_index = out_index_r;
  assign out_poly_value = out_value_r;
  assign out_last       = out_last_r;

  // sequencer
  opb_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_value   (in_value),
    .in_ready   (in_ready),
    .basis_kind (kind_r),
    .basis_size (size_r),
    .slot_free  (slot_free),
    .emit       (emit),
    .req        (req),
    .mrs_done   (mrs_done),
    .mrs_res    (mrs_res)
  );

  // shared multiply unit
  opb_mrs_unit u_mrs (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (mrs_done),
    .res   (mrs_res)
  );

endmodule

[src/opb_checker.sv]
// port level checks for the polynomial basis evaluator, bound to the top level
module opb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [3:0]                      out_poly_index,
  input logic signed [63:0]              out_poly_value,
  input logic                            out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_poly_value) &&
      $stable(out_poly_index) && $stable(out_last))
    else $error("stalled result changed");

  // a sample request makes the block busy
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a sample request");

  // when idle, only the final result of a run may still wait
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_last)
    else $error("idle with a non-final result pending");

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind orthonormal_polynomial_basis_eval opb_checker u_opb_checker (.*);

[test/testbench.sv]
// self-checking testbench for the orthonormal polynomial basis evaluator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import opb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RESET_CYCLES = 7;
  localparam int PRINT_CAP    = 200;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 18;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // sample points in Q4.28
  localparam logic signed [31:0] X_ONE  = 32'sh1000_0000;
  localparam logic signed [31:0] X_HALF = 32'sh0800_0000;
  localparam logic signed [31:0] X_TWO  = 32'sh2000_0000;
  localparam logic signed [31:0] X_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] X_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]         degree;
    logic signed [63:0] value;
    logic               is_last;
  } poly_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic signed [31:0]    in_value  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            out_poly_index;
  logic signed [63:0]    out_poly_value;
  logic                  out_last;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow copy of the configuration registers
  logic            kind_shadow = KIND_HERMITE;
  logic [4:0]      size_shadow = BASIS_SIZE_RESET;

  poly_result_t       expected_polys[$];
  logic signed [31:0] queued_samples[$];
  int                 mismatch_count = 0;
  int                 cycle_count    = 0;
  bit                 req_taken      = 1'b0;
  bit                 gaps_on        = 1'b1;
  int                 send_gap       = 0;
  int                 stall_left     = 0;

  orthonormal_polynomial_basis_eval dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_poly_index (out_poly_index),
    .out_poly_value (out_poly_value),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // floor of the square root of a 64-bit value
  function automatic logic [31:0] root_floor(input logic [63:0] t);
    logic [31:0] r;
    logic [31:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= t) r = trial;
    end
    return r;
  endfunction

  // v * coef / 2^sh, rounded half away from zero, clipped to 64 bits
  function automatic logic signed [63:0] scale_round_sat(input logic signed [63:0] v,
      input logic [31:0] coef, input logic coef_neg, input int sh);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] hi_prod;
    logic [63:0] lo_prod;
    logic [63:0] lim;
    logic [63:0] m;
    neg     = v[63] ^ coef_neg;
    mag     = v[63] ? 64'd0 - v : v;
    hi_prod = {32'd0, mag[63:32]} * {32'd0, coef};
    lo_prod = {32'd0, mag[31:0]} * {32'd0, coef};
    lim     = neg ? NEG_LIM : POS_LIM;
    if (hi_prod > (lim >> (32 - sh))) begin
      m = lim;
    end else begin
      m = (hi_prod << (32 - sh)) + ((lo_prod + (64'd1 << (sh - 1))) >> sh);
      if (m > lim) m = lim;
    end
    return neg ? 64'd0 - m : m;
  endfunction

  // a - b clipped to the signed 64-bit range
  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
      input logic signed [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? NEG_LIM : POS_LIM;
    return d[63:0];
  endfunction

  // recurrence over all degrees of one sample, results queued in order
  function automatic void predict_basis_run(input logic signed [31:0] x);
    logic               x_neg;
    logic [31:0]        x_mag;
    logic signed [63:0] prev;
    logic signed [63:0] cur;
    logic signed [63:0] t;
    logic signed [63:0] p;
    logic signed [63:0] q;
    logic [63:0]        k;
    logic [63:0]        a;
    logic [63:0]        b;
    logic [31:0]        r;
    logic [31:0]        s;
    int                 n;
    poly_result_t       res;
    x_neg = x[31];
    x_mag = x_neg ? 32'd0 - x : x;
    n = size_shadow;
    if (n < 1) n = 1;
    if (n > MAX_BASIS) n = MAX_BASIS;
    prev = '0;
    cur  = ONE_Q32;
    for (int i = 0; i < n; i++) begin
      res.degree  = 4'(i);
      res.value   = cur;
      res.is_last = (i == n - 1);
      expected_polys = {expected_polys, res};
      k = 64'(i) + 64'd1;
      t = scale_round_sat(cur, x_mag, x_neg, 28);
      if (kind_shadow == KIND_HERMITE) begin
        r = root_floor(TWO_P62 / k);
        s = root_floor(TWO_P62 - (TWO_P62 + 64'(i)) / k);
        p = scale_round_sat(t, r, 1'b0, 31);
        q = scale_round_sat(prev, s, 1'b0, 31);
      end else begin
        a = ((64'(2 * i + 1) << 30) + k / 2) / k;
        b = ((64'(i) << 31) + k / 2) / k;
        p = scale_round_sat(t, a[31:0], 1'b0, 30);
        q = scale_round_sat(prev, b[31:0], 1'b0, 31);
      end
      prev = cur;
      cur  = sub_sat(p, q);
    end
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random sample: full range, the interesting band, extremes, near zero
  function automatic logic signed [31:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $urandom;
    if (roll < 8) return $signed($urandom_range(0, 32'h4000_0000)) - X_TWO;
    if (roll == 8) begin
      case ($urandom_range(0, 3))
        0:       return X_MAX;
        1:       return X_MIN;
        2:       return X_ONE;
        default: return -X_ONE;
      endcase
    end
    return $signed($urandom_range(0, 64)) - 32'sd32;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
      input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_BASIS_KIND) kind_shadow = data[0];
    else if (idx == REG_BASIS_SIZE) size_shadow = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every queued sample is taken and all its degrees have come back
  task automatic wait_drained();
    do @(posedge clk);
    while (queued_samples.size() != 0 || in_valid || expected_polys.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // sample requests, one at a time with random gaps
  always @(negedge clk) begin : sample_driver
    logic               v_next;
    logic signed [31:0] d_next;
    v_next = in_valid;
    d_next = in_value;
    if (!rst_n) begin
      v_next = 1'b0;
    end else begin
      if (req_taken) begin
        v_next    = 1'b0;
        req_taken = 1'b0;
      end
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_samples.size() > 0) begin
          v_next   = 1'b1;
          d_next   = queued_samples.pop_front();
          send_gap = pick_gap();
        end
      end
    end
    in_valid <= v_next;
    in_value <= d_next;
  end

  // result side back-pressure
  always @(negedge clk) begin : result_sink
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // result checking and prediction of each accepted request
  always @(posedge clk) begin : monitor
    poly_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_polys.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, degree %0d value %h",
                                  out_poly_index, out_poly_value));
        end else begin
          want = expected_polys.pop_front();
          if (out_poly_index !== want.degree)
            flag_mismatch($sformatf("degree %0d, expected %0d", out_poly_index, want.degree));
          if (out_poly_value !== want.value)
            flag_mismatch($sformatf("degree %0d value %h, expected %h",
                                    want.degree, out_poly_value, want.value));
          if (out_last !== want.is_last)
            flag_mismatch($sformatf("degree %0d last %b, expected %b",
                                    want.degree, out_last, want.is_last));
        end
      end
      if (in_valid && in_ready) begin
        predict_basis_run(in_value);
        req_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4:0] size_pick;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: hermite, eight degrees
    queued_samples = '{32'sd0, X_ONE, -X_ONE};
    wait_drained();

    // full hermite basis at the extremes of the sample range
    write_reg(REG_BASIS_SIZE, 5'd16);
    queued_samples = '{X_MAX, X_MIN, X_TWO, -X_TWO, 32'sd1, -32'sd1};
    wait_drained();

    // full legendre basis, large samples clip
    write_reg(REG_BASIS_KIND, {4'd0, KIND_LEGENDRE});
    queued_samples = '{X_MAX, X_MIN, X_ONE, -X_ONE, X_HALF, 32'sd0};
    wait_drained();

    // size zero gives a single degree
    write_reg(REG_BASIS_SIZE, 5'd0);
    queued_samples = '{-X_HALF};
    wait_drained();

    // sizes past the basis limit give the full basis
    write_reg(REG_BASIS_SIZE, 5'd31);
    queued_samples = '{X_TWO};
    wait_drained();
    write_reg(REG_BASIS_SIZE, 5'd17);
    queued_samples = '{-X_TWO};
    wait_drained();

    // write to an unused index leaves both registers alone
    write_reg(REG_SPARE, 5'h1F);
    queued_samples = '{X_MIN};
    wait_drained();

    // only the low bit of the kind write counts
    write_reg(REG_BASIS_KIND, 5'b11110);
    write_reg(REG_BASIS_SIZE, 5'd1);
    queued_samples = '{X_MAX};
    wait_drained();

    // random phases, each with its own configuration; every third without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gaps_on = (ph % 3 != 2);
      write_reg(REG_BASIS_KIND, 5'($urandom_range(0, 31)));
      case ($urandom_range(0, 5))
        0:       size_pick = 5'd1;
        1:       size_pick = 5'd16;
        2:       size_pick = 5'($urandom_range(17, 31));
        default: size_pick = 5'($urandom_range(2, 15));
      endcase
      write_reg(REG_BASIS_SIZE, size_pick);
      for (int j = 0; j < PHASE_ITEMS; j++) queued_samples = {queued_samples, pick_sample()};
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
